[design/wrapped_phase_laplacian_3d_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the wrapped phase Laplacian block
// Shared concurrent check forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WRAPPED_PHASE_LAPLACIAN_3D_TOP_DEFINES_SVH
`define WRAPPED_PHASE_LAPLACIAN_3D_TOP_DEFINES_SVH

// cons holds in the same cycle as ante
`define WPL3D_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons holds in the cycle after ante
`define WPL3D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/wpl3d_pkg.sv]
// ----------------------------------------------------------------------------
// wpl3d_pkg
// Types, widths and fixed-point constants of the wrapped phase Laplacian.
// ----------------------------------------------------------------------------
package wpl3d_pkg;

	localparam int FRAC_BITS  = 12;
	localparam int PHASE_W    = 16;
	localparam int LAP_W      = 21;
	localparam int SIZE_W     = 9;
	localparam int COORD_W    = 8;
	localparam int SXY_W      = 17;
	localparam int IDX_W      = 25;
	localparam int CD_W       = 19;
	localparam int ACC_W      = 22;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int MAP_W      = 34;
	localparam int INT13_SH   = 13;

	// 2pi in Q32, rounded to nearest to Q.FRAC_BITS
	localparam longint TWOPI_Q32 = 64'sd26986075409;
	localparam longint TWOPI_QL  =
		(TWOPI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);

	localparam logic signed [CD_W+1:0]  TWOPI_CD  = (CD_W+2)'(TWOPI_QL);
	localparam logic signed [PHASE_W:0] TWOPI_MUL = (PHASE_W+1)'(TWOPI_QL);
	localparam logic signed [PHASE_W:0] INT13_OFS = (PHASE_W+1)'(4096);
	localparam logic signed [MAP_W-1:0] INT13_RND = MAP_W'(4096);

	localparam logic signed [MAP_W-1:0] PH_HI = MAP_W'((64'sd1 <<< (PHASE_W-1)) - 1);
	localparam logic signed [MAP_W-1:0] PH_LO = -PH_HI - MAP_W'(1);
	localparam logic signed [ACC_W-1:0] LAP_HI = ACC_W'((64'sd1 <<< (LAP_W-1)) - 1);
	localparam logic signed [ACC_W-1:0] LAP_LO = -LAP_HI - ACC_W'(1);

	localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(1);
	localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(256);

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TWO_D  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INT13  = 3'd4;

	typedef logic signed [PHASE_W-1:0] phase_t;
	typedef logic signed [LAP_W-1:0]   lap_t;
	typedef logic signed [CD_W-1:0]    cd_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [SIZE_W-1:0]         size_t;
	typedef logic [COORD_W-1:0]        coord_t;

	typedef struct packed {
		size_t             sx;
		size_t             sy;
		size_t             sz;
		logic [SXY_W-1:0]  sxy;
		idx_t              total;
		logic              two_d;
		logic              int13;
		logic              settled;
		logic              clear;
	} cfg_t;

endpackage

[design/wpl3d_cmd_if.sv]
// ----------------------------------------------------------------------------
// wpl3d_cmd_if
// Command channel: load a phase sample or request one Laplacian result.
// ----------------------------------------------------------------------------
interface wpl3d_cmd_if import wpl3d_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   func;
	phase_t phase_sample;

	modport source (output valid, output func, output phase_sample, input ready);
	modport sink (input valid, input func, input phase_sample, output ready);
endinterface

[design/wpl3d_res_if.sv]
// ----------------------------------------------------------------------------
// wpl3d_res_if
// Result channel: Laplacian of one voxel and the last-voxel flag.
// ----------------------------------------------------------------------------
interface wpl3d_res_if import wpl3d_pkg::*; ();
	logic valid;
	logic ready;
	lap_t laplacian;
	logic last_voxel;

	modport source (output valid, output laplacian, output last_voxel, input ready);
	modport sink (input valid, input laplacian, input last_voxel, output ready);
endinterface

[design/wpl3d_cfg_if.sv]
// ----------------------------------------------------------------------------
// wpl3d_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wpl3d_cfg_if import wpl3d_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[design/wpl3d_circ.sv]
// ----------------------------------------------------------------------------
// wpl3d_circ
// Circular difference b - a, folded by 2pi toward the smallest magnitude.
// ----------------------------------------------------------------------------
module wpl3d_circ import wpl3d_pkg::*; (
	input  cd_t a,
	input  cd_t b,
	output cd_t y
);

	function automatic logic [CD_W+1:0] mag_of(input logic signed [CD_W+1:0] v);
		mag_of = v[CD_W+1] ? $unsigned(-v) : $unsigned(v);
	endfunction

	logic signed [CD_W:0]   d;
	logic signed [CD_W+1:0] d_x;
	logic signed [CD_W+1:0] up;
	logic signed [CD_W+1:0] dn;
	logic [CD_W+1:0]        mag_d;
	logic [CD_W+1:0]        mag_up;
	logic [CD_W+1:0]        mag_dn;

	assign d      = (CD_W+1)'(b) - (CD_W+1)'(a);
	assign d_x    = (CD_W+2)'(d);
	assign up     = d_x + TWOPI_CD;
	assign dn     = d_x - TWOPI_CD;
	assign mag_d  = mag_of(d_x);
	assign mag_up = mag_of(up);
	assign mag_dn = mag_of(dn);

	always_comb begin
		priority if (mag_up < mag_d) begin
			y = up[CD_W-1:0];
		end else if (mag_dn < mag_d) begin
			y = dn[CD_W-1:0];
		end else begin
			y = d_x[CD_W-1:0];
		end
	end

endmodule

[design/wpl3d_store.sv]
// ----------------------------------------------------------------------------
// wpl3d_store
// Single-port phase store, registered read data.
// ----------------------------------------------------------------------------
module wpl3d_store import wpl3d_pkg::*; #(
	parameter int DEPTH = 32768,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  phase_t        wdata,
	output phase_t        rdata
);

	phase_t mem_q [DEPTH];
	phase_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/wpl3d_cfg.sv]
// ----------------------------------------------------------------------------
// wpl3d_cfg
// Configuration registers, size clamping and volume extent products.
// ----------------------------------------------------------------------------
module wpl3d_cfg import wpl3d_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	wpl3d_cfg_if.sink     cfg,
	output cfg_t          regs
);

	localparam logic [1:0] SETTLE_CYC = 2'd2;

	size_t                    sx_q;
	size_t                    sy_q;
	size_t                    sz_q;
	logic [SXY_W-1:0]         sxy_q;
	idx_t                     total_q;
	logic                     two_d_q;
	logic                     int13_q;
	logic [1:0]               settle_q;
	size_t                    wr_size;
	logic                     clear;
	logic [2*SIZE_W-1:0]      sxy_full;
	logic [SXY_W+SIZE_W-1:0]  total_full;

	assign cfg.ready = 1'b1;

	always_comb begin
		priority if (cfg.data == '0) begin
			wr_size = SIZE_MIN;
		end else if (cfg.data > SIZE_MAX) begin
			wr_size = SIZE_MAX;
		end else begin
			wr_size = cfg.data;
		end
	end

	assign clear = cfg.valid && (cfg.index == REG_SIZE_X || cfg.index == REG_SIZE_Y ||
		cfg.index == REG_SIZE_Z);

	assign sxy_full   = sx_q * sy_q;
	assign total_full = sxy_q * sz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q     <= SIZE_MIN;
			sy_q     <= SIZE_MIN;
			sz_q     <= SIZE_MIN;
			sxy_q    <= SXY_W'(1);
			total_q  <= IDX_W'(1);
			two_d_q  <= 1'b0;
			int13_q  <= 1'b0;
			settle_q <= '0;
		end else begin
			sxy_q   <= sxy_full[SXY_W-1:0];
			total_q <= total_full[IDX_W-1:0];
			if (clear) begin
				settle_q <= SETTLE_CYC;
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 2'd1;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_SIZE_X: sx_q    <= wr_size;
					REG_SIZE_Y: sy_q    <= wr_size;
					REG_SIZE_Z: sz_q    <= wr_size;
					REG_TWO_D:  two_d_q <= cfg.data[0];
					REG_INT13:  int13_q <= cfg.data[0];
					default: begin
					end
				endcase
			end
		end
	end

	assign regs.sx      = sx_q;
	assign regs.sy      = sy_q;
	assign regs.sz      = sz_q;
	assign regs.sxy     = sxy_q;
	assign regs.total   = total_q;
	assign regs.two_d   = two_d_q;
	assign regs.int13   = int13_q;
	assign regs.settled = (settle_q == '0);
	assign regs.clear   = clear;

endmodule

[design/wrapped_phase_laplacian_3d_top.sv]
// ----------------------------------------------------------------------------
// wrapped_phase_laplacian_3d_top
// Loads a phase volume into a single-port store, then returns the wrapped
// central-difference Laplacian of each voxel in x-fastest order.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                  One transaction
// cmd      in   func, phase_sample       load one sample / request one result
// res      out  laplacian, last_voxel    result of one accepted request
// cfg      in   index, data              one register write
//
// A load writes its sample in S_LDW. A request runs S_A0 to S_A3 per axis
// (z only outside 2-D mode), paced by the store's single port (up to three
// reads per axis) and the one circular-difference unit (three passes per
// axis). A request before the volume is complete is taken and dropped.
// Reset sets sizes to 1 and clears state, counters and flags, not the store.
// A size write stalls cmd until the extents settle. A finished result waits in
// the output register while the next command is taken; a later result waits
// in its last step until that register is free.
// ----------------------------------------------------------------------------
`include "wrapped_phase_laplacian_3d_top_defines.svh"

module wrapped_phase_laplacian_3d_top import wpl3d_pkg::*; #(
	parameter int MAX_VOXELS = 32768
) (
	input  logic          clk,
	input  logic          arst_n,
	wpl3d_cmd_if.sink     cmd,
	wpl3d_res_if.source   res,
	wpl3d_cfg_if.sink     cfg
);

	localparam int   AW   = $clog2(MAX_VOXELS);
	localparam idx_t MAXV = IDX_W'(MAX_VOXELS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LDW  = 3'd1;
	localparam logic [2:0] S_CTR  = 3'd2;
	localparam logic [2:0] S_A0   = 3'd3;
	localparam logic [2:0] S_A1   = 3'd4;
	localparam logic [2:0] S_A2   = 3'd5;
	localparam logic [2:0] S_A3   = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	cfg_t                     regs;
	logic [2:0]               state_q;
	logic [1:0]               ax_q;
	idx_t                     lc_q;
	idx_t                     rc_q;
	idx_t                     wr_idx_q;
	logic                     wr_ok_q;
	logic                     loaded_q;
	coord_t                   rx_q;
	coord_t                   ry_q;
	coord_t                   rz_q;
	phase_t                   samp_q;
	logic signed [MAP_W-1:0]  prod_q;
	phase_t                   f0_q;
	cd_t                      gl_q;
	cd_t                      gr_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     last_q;
	logic                     rd_oob_q;
	lap_t                     out_lap_q;
	logic                     out_last_q;
	logic                     out_valid_q;

	logic                     cmd_fire;
	logic                     load_go;
	logic                     read_go;
	logic                     out_free;
	idx_t                     lc_base;
	idx_t                     lc_next;
	idx_t                     rc_inc;
	logic signed [PHASE_W:0]  raw_ofs;
	logic signed [MAP_W-1:0]  prod_d;
	logic signed [MAP_W-1:0]  rnd;
	logic signed [MAP_W-1:0]  shifted;
	phase_t                   mapped;
	phase_t                   st_wdata;
	phase_t                   st_rdata;
	phase_t                   fetched;
	logic                     st_we;
	idx_t                     st_idx;
	coord_t                   c;
	size_t                    n;
	logic [SXY_W-1:0]         stride;
	size_t                    c9;
	logic                     interior;
	logic                     lo_en;
	logic                     hi_en;
	idx_t                     idx_lo;
	idx_t                     idx_hi;
	cd_t                      ua;
	cd_t                      ub;
	cd_t                      uy;
	lap_t                     lap_sat;

	wpl3d_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// handshakes
	assign cmd.ready = (state_q == S_IDLE) && regs.settled;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign load_go   = cmd_fire && (cmd.func == FUNC_LOAD);
	assign read_go   = cmd_fire && (cmd.func == FUNC_READ) && loaded_q;
	assign out_free  = !out_valid_q || res.ready;

	assign lc_base = loaded_q ? '0 : lc_q;
	assign lc_next = lc_base + IDX_W'(1);
	assign rc_inc  = rc_q + IDX_W'(1);

	// int13 mapping: (k + 4096) * 2pi / 8192, round half up, saturate
	assign raw_ofs = (PHASE_W+1)'(cmd.phase_sample) + INT13_OFS;
	assign prod_d  = raw_ofs * TWOPI_MUL;
	assign rnd     = prod_q + INT13_RND;
	assign shifted = rnd >>> INT13_SH;

	always_comb begin
		priority if (shifted > PH_HI) begin
			mapped = PH_HI[PHASE_W-1:0];
		end else if (shifted < PH_LO) begin
			mapped = PH_LO[PHASE_W-1:0];
		end else begin
			mapped = shifted[PHASE_W-1:0];
		end
	end

	assign st_wdata = regs.int13 ? mapped : samp_q;

	// axis select
	always_comb begin
		unique case (ax_q)
			AX_X: begin
				c      = rx_q;
				n      = regs.sx;
				stride = SXY_W'(1);
			end
			AX_Y: begin
				c      = ry_q;
				n      = regs.sy;
				stride = SXY_W'(regs.sx);
			end
			AX_Z: begin
				c      = rz_q;
				n      = regs.sz;
				stride = regs.sxy;
			end
			default: begin
				c      = '0;
				n      = SIZE_MIN;
				stride = '0;
			end
		endcase
	end

	assign c9       = {1'b0, c};
	assign interior = (c != '0) && (c9 + SIZE_W'(1) < n);
	assign lo_en    = interior && (c9 >= SIZE_W'(2));
	assign hi_en    = interior && (c9 + SIZE_W'(2) < n);
	assign idx_lo   = rc_q - IDX_W'({stride, 1'b0});
	assign idx_hi   = rc_q + IDX_W'({stride, 1'b0});

	// store port
	always_comb begin
		st_we  = 1'b0;
		st_idx = rc_q;
		unique case (state_q)
			S_LDW: begin
				st_we  = wr_ok_q;
				st_idx = wr_idx_q;
			end
			S_A0:    st_idx = idx_lo;
			S_A1:    st_idx = idx_hi;
			default: st_idx = rc_q;
		endcase
	end

	wpl3d_store #(
		.DEPTH (MAX_VOXELS)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.addr  (st_idx[AW-1:0]),
		.wdata (st_wdata),
		.rdata (st_rdata)
	);

	assign fetched = rd_oob_q ? '0 : st_rdata;

	// shared circular-difference unit
	always_comb begin
		unique case (state_q)
			S_A1: begin
				ua = CD_W'(fetched);
				ub = CD_W'(f0_q);
			end
			S_A2: begin
				ua = CD_W'(f0_q);
				ub = CD_W'(fetched);
			end
			default: begin
				ua = gl_q;
				ub = gr_q;
			end
		endcase
	end

	wpl3d_circ u_circ (
		.a (ua),
		.b (ub),
		.y (uy)
	);

	always_comb begin
		priority if (acc_q > LAP_HI) begin
			lap_sat = LAP_HI[LAP_W-1:0];
		end else if (acc_q < LAP_LO) begin
			lap_sat = LAP_LO[LAP_W-1:0];
		end else begin
			lap_sat = acc_q[LAP_W-1:0];
		end
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ax_q        <= AX_X;
			lc_q        <= '0;
			rc_q        <= '0;
			loaded_q    <= 1'b0;
			wr_ok_q     <= 1'b0;
			rx_q        <= '0;
			ry_q        <= '0;
			rz_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (load_go) begin
						wr_ok_q  <= (lc_base < MAXV);
						lc_q     <= lc_next;
						loaded_q <= (lc_next >= regs.total);
						if (loaded_q || lc_next >= regs.total) begin
							rc_q <= '0;
							rx_q <= '0;
							ry_q <= '0;
							rz_q <= '0;
						end
						state_q <= S_LDW;
					end else if (read_go) begin
						state_q <= S_CTR;
					end
				end
				S_LDW: state_q <= S_IDLE;
				S_CTR: begin
					ax_q    <= AX_X;
					state_q <= S_A0;
				end
				S_A0: state_q <= S_A1;
				S_A1: state_q <= S_A2;
				S_A2: state_q <= S_A3;
				S_A3: begin
					priority if (ax_q == AX_X) begin
						ax_q    <= AX_Y;
						state_q <= S_A0;
					end else if (ax_q == AX_Y && !regs.two_d) begin
						ax_q    <= AX_Z;
						state_q <= S_A0;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (rc_inc >= regs.total) begin
							rc_q <= '0;
							rx_q <= '0;
							ry_q <= '0;
							rz_q <= '0;
						end else begin
							rc_q <= rc_inc;
							if ({1'b0, rx_q} + SIZE_W'(1) == regs.sx) begin
								rx_q <= '0;
								if ({1'b0, ry_q} + SIZE_W'(1) == regs.sy) begin
									ry_q <= '0;
									rz_q <= rz_q + COORD_W'(1);
								end else begin
									ry_q <= ry_q + COORD_W'(1);
								end
							end else begin
								rx_q <= rx_q + COORD_W'(1);
							end
						end
					end
				end
			endcase
			if (regs.clear) begin
				lc_q     <= '0;
				rc_q     <= '0;
				loaded_q <= 1'b0;
				rx_q     <= '0;
				ry_q     <= '0;
				rz_q     <= '0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		rd_oob_q <= (st_idx >= MAXV);
		if (load_go) begin
			wr_idx_q <= lc_base;
			samp_q   <= cmd.phase_sample;
			prod_q   <= prod_d;
		end
		if (read_go) begin
			last_q <= (rc_inc == regs.total);
		end
		unique case (state_q)
			S_CTR: acc_q <= '0;
			S_A0: begin
				if (ax_q == AX_X) begin
					f0_q <= fetched;
				end
			end
			S_A1: gl_q <= lo_en ? uy : '0;
			S_A2: gr_q <= hi_en ? uy : '0;
			S_A3: acc_q <= acc_q + ACC_W'(uy);
			S_OUT: begin
				if (out_free) begin
					out_lap_q  <= lap_sat;
					out_last_q <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid      = out_valid_q;
	assign res.laplacian  = out_lap_q;
	assign res.last_voxel = out_last_q;

	`WPL3D_ASSERT_IMPLY(a_res_from_read, $rose(out_valid_q), $past(state_q) == S_OUT,
		"result raised outside the output step")
	`WPL3D_ASSERT_IMPLY(a_load_bound, regs.settled, lc_q <= regs.total,
		"load count beyond volume size")
	`WPL3D_ASSERT_IMPLY(a_read_bound, loaded_q && regs.settled, rc_q < regs.total,
		"read count beyond volume size")
	`WPL3D_ASSERT_IMPLY(a_coord_bound, loaded_q,
		({1'b0, rx_q} < regs.sx) && ({1'b0, ry_q} < regs.sy) && ({1'b0, rz_q} < regs.sz),
		"voxel coordinate out of range")
	`WPL3D_ASSERT_NEXT(a_reload, load_go && loaded_q && !regs.clear, lc_q == IDX_W'(1),
		"reload of a complete volume did not restart the count")

endmodule

[verif/wrapped_phase_laplacian_3d_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrapped_phase_laplacian_3d_top_test
// Self-checking bench for the wrapped phase Laplacian. A clocked driver feeds
// load and read commands from a backlog. A clocked monitor keeps its own copy
// of the phase volume, counters and registers. It predicts each Laplacian and
// last-voxel flag and checks every result in order. A short directed part
// covers extreme samples and wrap ties, reset sizes, reads before the load is
// complete, read wrap, reload and int13 mapping. Random volumes follow with
// sender bursts, receiver stalls and long receiver hold-offs in phase 2.
// ----------------------------------------------------------------------------
module wrapped_phase_laplacian_3d_top_test;
	import wpl3d_pkg::*;

	localparam int          STORE_DEPTH  = 32768;
	localparam longint      TWO_PI_FX    = 25736;
	localparam longint      LAP_MAX_FX   = 64'sd1048575;
	localparam longint      LAP_MIN_FX   = -64'sd1048576;
	localparam int          SETTLE_CYC   = 40;
	localparam int          HOLD_CYC     = 300;
	localparam int unsigned RANDOM_ITEMS = 1900;
	localparam longint      CYCLE_LIMIT  = 3000000;

	typedef struct {
		logic   func;
		phase_t ph;
	} cmd_item_t;

	typedef struct {
		lap_t laplacian;
		logic last_voxel;
	} lap_result_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cmd_valid  = 1'b0;
	logic                  cmd_func   = FUNC_LOAD;
	phase_t                cmd_sample = '0;
	logic                  res_ready  = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = REG_SIZE_X;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	wpl3d_cmd_if cmd_ch();
	wpl3d_res_if res_ch();
	wpl3d_cfg_if cfg_ch();

	assign cmd_ch.valid        = cmd_valid;
	assign cmd_ch.func         = cmd_func;
	assign cmd_ch.phase_sample = cmd_sample;
	assign res_ch.ready        = res_ready;
	assign cfg_ch.valid        = cfg_valid;
	assign cfg_ch.index        = cfg_index;
	assign cfg_ch.data         = cfg_data;

	wrapped_phase_laplacian_3d_top #(.MAX_VOXELS(STORE_DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mirror of the block state
	logic [SIZE_W-1:0] vol_dim [3] = '{9'd1, 9'd1, 9'd1};
	logic              flat_mode  = 1'b0;
	logic              raw_mode   = 1'b0;
	phase_t            phase_mem [STORE_DEPTH];
	int unsigned       loaded_cnt = 0;
	int unsigned       served_cnt = 0;
	logic              vol_full   = 1'b0;

	lap_result_t laplacians_due [$];
	cmd_item_t   cmd_backlog [$];
	int unsigned fault_cnt = 0;

	// traffic shaping, written by the stimulus at the start of or during a phase
	int unsigned gap_max     = 0;
	logic [15:0] rx_shape    = 16'hFFFF;
	logic        hold_toggle = 1'b0;

	function automatic int unsigned eff_dim(logic [SIZE_W-1:0] raw);
		if (raw == 0) return 1;
		if (raw > 256) return 256;
		return int'(raw);
	endfunction

	function automatic longint stored_phase(int unsigned idx);
		if (idx >= STORE_DEPTH) return 0;
		return longint'(phase_mem[idx]);
	endfunction

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint wrap_diff(longint lo, longint hi);
		longint d, up, dn;
		d  = hi - lo;
		up = d + TWO_PI_FX;
		dn = d - TWO_PI_FX;
		if (magnitude(up) < magnitude(d)) return up;
		if (magnitude(dn) < magnitude(d)) return dn;
		return d;
	endfunction

	function automatic longint phase_grad(int unsigned idx, c, n, stride);
		if (c == 0 || c + 1 >= n) return 0;
		return wrap_diff(stored_phase(idx - stride), stored_phase(idx + stride));
	endfunction

	function automatic longint axis_curv(int unsigned idx, c, n, stride);
		if (c == 0 || c + 1 >= n) return 0;
		return wrap_diff(phase_grad(idx - stride, c - 1, n, stride),
			phase_grad(idx + stride, c + 1, n, stride));
	endfunction

	// raw int13 sample to 0..2pi, rounded half up, saturated to 16 bits
	function automatic phase_t raw_to_phase(phase_t k);
		longint r;
		r = ((longint'(k) + 4096) * TWO_PI_FX + 4096) >>> 13;
		if (r > 32767) r = 32767;
		else if (r < -32768) r = -32768;
		return phase_t'(r);
	endfunction

	task automatic set_volume_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		unique case (idx)
			REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: begin
				vol_dim[idx[1:0]] = data;
				loaded_cnt        = 0;
				served_cnt        = 0;
				vol_full          = 1'b0;
			end
			REG_TWO_D: flat_mode = data[0];
			REG_INT13: raw_mode = data[0];
			default: ;
		endcase
	endtask

	task automatic step_volume(logic func, phase_t ph);
		int unsigned sx, sy, sz, total, i;
		longint      lap;
		lap_result_t r;
		sx    = eff_dim(vol_dim[0]);
		sy    = eff_dim(vol_dim[1]);
		sz    = eff_dim(vol_dim[2]);
		total = sx * sy * sz;
		if (func == FUNC_LOAD) begin
			if (vol_full) begin
				loaded_cnt = 0;
				served_cnt = 0;
				vol_full   = 1'b0;
			end
			if (loaded_cnt < STORE_DEPTH) phase_mem[loaded_cnt] = raw_mode ? raw_to_phase(ph) : ph;
			loaded_cnt++;
			if (loaded_cnt >= total) begin
				vol_full   = 1'b1;
				served_cnt = 0;
			end
		end else if (vol_full) begin
			if (served_cnt >= total) served_cnt = 0;
			i   = served_cnt;
			lap = axis_curv(i, i % sx, sx, 1) + axis_curv(i, (i / sx) % sy, sy, sx);
			if (!flat_mode) lap += axis_curv(i, i / (sx * sy), sz, sx * sy);
			if (lap > LAP_MAX_FX) lap = LAP_MAX_FX;
			else if (lap < LAP_MIN_FX) lap = LAP_MIN_FX;
			r.laplacian  = lap_t'(lap);
			r.last_voxel = (i + 1 == total);
			laplacians_due.push_back(r);
			served_cnt = (i + 1 >= total) ? 0 : i + 1;
		end
	endtask

	task automatic note_fault(string msg);
		fault_cnt++;
		if (fault_cnt <= 10) $display("ERROR: %s", msg);
	endtask

	// command driver: bursts of random length, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		cmd_item_t          item;
		static int unsigned burst_left = 0;
		static int unsigned gap_left   = 0;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_ch.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_valid <= 1'b0;
			end else if (cmd_backlog.size() > 0) begin
				item = cmd_backlog.pop_front();
				cmd_valid  <= 1'b1;
				cmd_func   <= item.func;
				cmd_sample <= item.ph;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 7);
					if (gap_max > 0) gap_left = $urandom_range(0, gap_max);
				end
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// result receiver: rotating stall pattern, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		static logic        hold_last = 1'b0;
		static int unsigned hold_left = 0;
		static logic [3:0]  rx_pos    = '0;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (hold_toggle != hold_last) begin
			hold_last = hold_toggle;
			hold_left = HOLD_CYC;
			res_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= rx_shape[rx_pos];
			rx_pos++;
		end
	end

	// monitor: tracks accepted transactions and checks results in order
	always @(posedge clk) begin
		lap_result_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ready) begin
				if (laplacians_due.size() == 0) begin
					note_fault($sformatf("unexpected result laplacian=%0d last_voxel=%0b",
						res_ch.laplacian, res_ch.last_voxel));
				end else begin
					want = laplacians_due.pop_front();
					if (res_ch.laplacian !== want.laplacian || res_ch.last_voxel !== want.last_voxel)
						note_fault($sformatf("laplacian exp %0d got %0d, last_voxel exp %0b got %0b",
							want.laplacian, res_ch.laplacian, want.last_voxel, res_ch.last_voxel));
				end
			end
			if (cfg_valid && cfg_ch.ready) set_volume_reg(cfg_index, cfg_data);
			if (cmd_valid && cmd_ch.ready) step_volume(cmd_func, cmd_sample);
		end
	end

	longint unsigned cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic push_cmd(logic func, phase_t ph);
		cmd_item_t it;
		it.func = func;
		it.ph   = ph;
		cmd_backlog.push_back(it);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(data);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		do @(negedge clk); while (cmd_backlog.size() != 0 || cmd_valid || laplacians_due.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	function automatic phase_t pick_sample(logic raw);
		int unsigned pick;
		pick = $urandom_range(0, 5);
		if (pick == 0) return phase_t'($urandom);
		if (raw) return phase_t'(int'($urandom_range(0, 8192)) - 4096);
		if (pick == 1) return phase_t'(6434 * (int'($urandom_range(0, 10)) - 5));
		if (pick == 2) return phase_t'(int'($urandom_range(0, 64)) - 32);
		return phase_t'(int'($urandom_range(0, 25736)) - 12868);
	endfunction

	task automatic random_volume(input int unsigned phase_no, inout int unsigned counted);
		int unsigned dim [3];
		int unsigned total, ncut, nreads, reps, v;
		logic        flat, raw, wide;
		foreach (dim[k]) dim[k] = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
		wide = (phase_no == 1 || phase_no == 4 || phase_no == 7);
		if (wide) begin
			dim = '{1, 1, 1};
			dim[(phase_no - 1) / 3] = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
		end
		if (phase_no == 2) dim = '{4, 4, 2};
		total = eff_dim(SIZE_W'(dim[0])) * eff_dim(SIZE_W'(dim[1])) * eff_dim(SIZE_W'(dim[2]));
		flat  = $urandom_range(0, 1);
		raw   = ($urandom_range(0, 3) == 0);
		gap_max  <= (phase_no == 2 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		rx_shape <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
		write_reg(REG_SIZE_X, dim[0]);
		write_reg(REG_SIZE_Y, dim[1]);
		write_reg(REG_SIZE_Z, dim[2]);
		write_reg(REG_TWO_D, flat);
		write_reg(REG_INT13, raw);
		reps = ($urandom_range(0, 3) == 0) ? 2 : 1;
		repeat (reps) begin
			if ($urandom_range(0, 3) == 0) push_cmd(FUNC_READ, phase_t'($urandom));
			ncut = ($urandom_range(0, 9) == 0 && total > 1) ? $urandom_range(1, total - 1) : total;
			for (v = 0; v < ncut; v++) push_cmd(FUNC_LOAD, pick_sample(raw));
			counted += ncut;
			if (ncut < total) begin
				settle();
				return;
			end
			if (phase_no == 2) begin
				while (cmd_backlog.size() != 0) @(negedge clk);
				hold_toggle <= ~hold_toggle;
			end else if ($urandom_range(0, 4) == 0) begin
				settle();
				flat = ~flat;
				write_reg(REG_TWO_D, flat);
			end
			nreads = wide ? $urandom_range(30, 60) : total + $urandom_range(0, total);
			repeat (nreads) push_cmd(FUNC_READ, phase_t'($urandom));
			counted += nreads;
		end
		settle();
	endtask

	initial begin
		static phase_t wrap_vals [5] = '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
			16'sd12868};
		static phase_t tie_vals  [5] = '{16'sd0, 16'sd12868, -16'sd12868, 16'sd25736, 16'sd0};
		static phase_t raw_vals  [5] = '{-16'sd32768, -16'sd4096, 16'sd0, 16'sd4096, 16'sd32767};
		int unsigned counted;
		int unsigned phase_no;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes: one-voxel volume
		push_cmd(FUNC_LOAD, 16'sd1234);
		repeat (2) push_cmd(FUNC_READ, '0);
		settle();

		write_reg(REG_SIZE_X, 5);
		write_reg(REG_SIZE_Y, 0);
		write_reg(REG_SIZE_Z, 1);
		write_reg(REG_TWO_D, 0);
		write_reg(REG_INT13, 0);
		push_cmd(FUNC_READ, '0);
		foreach (wrap_vals[k]) push_cmd(FUNC_LOAD, wrap_vals[k]);
		repeat (6) push_cmd(FUNC_READ, '0);
		foreach (tie_vals[k]) push_cmd(FUNC_LOAD, tie_vals[k]);
		repeat (3) push_cmd(FUNC_READ, '0);
		settle();

		write_reg(REG_INT13, 1);
		write_reg(REG_TWO_D, 1);
		foreach (raw_vals[k]) push_cmd(FUNC_LOAD, raw_vals[k]);
		repeat (3) push_cmd(FUNC_READ, '0);
		settle();

		counted  = 0;
		phase_no = 0;
		while (counted < RANDOM_ITEMS) begin
			random_volume(phase_no, counted);
			phase_no++;
		end

		settle();
		if (fault_cnt == 0 && laplacians_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[wrapped_phase_laplacian_3d_top.f]
+incdir+design
design/wpl3d_pkg.sv
design/wpl3d_cmd_if.sv
design/wpl3d_res_if.sv
design/wpl3d_cfg_if.sv
design/wpl3d_circ.sv
design/wpl3d_store.sv
design/wpl3d_cfg.sv
design/wrapped_phase_laplacian_3d_top.sv
verif/wrapped_phase_laplacian_3d_top_test.sv
